FILE: rtl/hrpt_pkg.sv
`default_nettype none
package hrpt_pkg;

    typedef enum logic [2:0] {
        OP_REGISTER   = 3'd0,
        OP_UNREGISTER = 3'd1,
        OP_PLACE      = 3'd2,
        OP_COMMIT     = 3'd3,
        OP_ABORT      = 3'd4,
        OP_TERMINATE  = 3'd5,
        OP_QUERY      = 3'd6,
        OP_NONE       = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NO_FIT    = 3'd4
    } t_status;

    localparam logic CFG_SEARCH_MODE = 1'b0;
    localparam logic CFG_LOCAL_KEY   = 1'b1;

    localparam logic SEARCH_FIRST_FIT    = 1'b0;
    localparam logic SEARCH_LEAST_LOADED = 1'b1;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_SCAN = 2'd1,
        BK_EXEC = 2'd2,
        BK_OUT  = 2'd3
    } t_bk_state;

    // one queued item as handed from front to back
    typedef struct packed {
        t_op         op;
        logic [15:0] key;
        logic [31:0] ram;
        logic [31:0] disk;
        logic [31:0] cpu;
        logic [31:0] addr;
        logic [15:0] port;
    } t_item;

endpackage
`default_nettype wire

FILE: rtl/host_resource_placement_table_top.sv
`default_nettype none
// Channel  Handshake        Payload
// in       valid / stall    mode, node_key, ram/disk/cpu amount, address, port
// out      valid / stall    status, chosen_key, chosen_address, chosen_port
// cfg      valid / ready    index (1 bit), data (16 bits)
// Each item is popped from the queue, scanned against every table slot, applied
// to the table and handed off; the engine pops the next only after the hand-off.
// Up to two items wait in the input queue while the engine works.
// Reset clears slot valid bits at once; no clearing pass.
module host_resource_placement_table_top #(
    parameter int NUM_HOSTS   = 16,
    parameter int AMOUNT_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic [15:0] i_node_key,
    input  wire logic [31:0] i_ram_amount,
    input  wire logic [31:0] i_disk_amount,
    input  wire logic [31:0] i_cpu_amount,
    input  wire logic [31:0] i_host_address,
    input  wire logic [15:0] i_host_port,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [15:0]      o_chosen_key,
    output logic [31:0]      o_chosen_address,
    output logic [15:0]      o_chosen_port,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import hrpt_pkg::*;

    logic        q_valid, q_pop;
    t_item       q_item;
    logic        r_search_mode;
    logic [15:0] r_local_key;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_mode <= SEARCH_FIRST_FIT;
            r_local_key   <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SEARCH_MODE) r_search_mode <= i_cfg_data[0];
            else r_local_key <= i_cfg_data;
        end
    end

    hrpt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_mode, .i_node_key, .i_ram_amount, .i_disk_amount, .i_cpu_amount,
        .i_host_address, .i_host_port,
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    hrpt_back #(.NUM_HOSTS(NUM_HOSTS), .AMOUNT_BITS(AMOUNT_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .i_search_mode(r_search_mode), .i_local_key(r_local_key),
        .o_valid, .i_stall, .o_status, .o_chosen_key, .o_chosen_address,
        .o_chosen_port
    );

endmodule
`default_nettype wire

FILE: rtl/hrpt_front.sv
`default_nettype none
// Input stage: registers accepted items, decodes the op, pushes into a 2-deep queue.
module hrpt_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [2:0]     i_mode,
    input  wire logic [15:0]    i_node_key,
    input  wire logic [31:0]    i_ram_amount,
    input  wire logic [31:0]    i_disk_amount,
    input  wire logic [31:0]    i_cpu_amount,
    input  wire logic [31:0]    i_host_address,
    input  wire logic [15:0]    i_host_port,
    output logic                o_q_valid,
    output hrpt_pkg::t_item     o_q_item,
    input  wire logic           i_q_pop
);
    import hrpt_pkg::*;

    t_item      r_q [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       push;
    t_item      in_item;

    // classify: modes map directly onto the op enum
    always_comb begin
        in_item.op   = t_op'(i_mode);
        in_item.key  = i_node_key;
        in_item.ram  = i_ram_amount;
        in_item.disk = i_disk_amount;
        in_item.cpu  = i_cpu_amount;
        in_item.addr = i_host_address;
        in_item.port = i_host_port;
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (i_q_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_q_pop) |=> o_stall) else $error("full queue not stalling");
`endif

endmodule
`default_nettype wire

FILE: rtl/hrpt_back.sv
`default_nettype none
// Table engine: scans slots one per cycle, then applies the op to at most one slot.
module hrpt_back #(
    parameter int NUM_HOSTS   = 16,
    parameter int AMOUNT_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire hrpt_pkg::t_item i_q_item,
    output logic                o_q_pop,
    input  wire logic           i_search_mode,
    input  wire logic [15:0]    i_local_key,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [2:0]          o_status,
    output logic [15:0]         o_chosen_key,
    output logic [31:0]         o_chosen_address,
    output logic [15:0]         o_chosen_port
);
    import hrpt_pkg::*;

    localparam int IW = $clog2(NUM_HOSTS);
    localparam int AW = AMOUNT_BITS;
    localparam logic [AW:0] AMAX = {1'b0, {AW{1'b1}}};

    // table (valid bits in flops, rest in per-slot registers)
    logic [NUM_HOSTS-1:0] r_valid;
    logic [15:0]   r_key   [NUM_HOSTS];
    logic [31:0]   r_addr  [NUM_HOSTS];
    logic [15:0]   r_port  [NUM_HOSTS];
    logic [AW-1:0] r_tot   [NUM_HOSTS][3];
    logic [AW-1:0] r_used  [NUM_HOSTS][3];
    logic [AW-1:0] r_held  [NUM_HOSTS][3];
    logic [7:0]    r_apps  [NUM_HOSTS];

    t_bk_state r_st, n_st;
    t_item     r_it;
    logic [IW-1:0] r_idx, n_idx;
    logic       r_found, n_found;
    logic [IW-1:0] r_fslot, n_fslot;
    logic       r_hasfree, n_hasfree;
    logic [IW-1:0] r_free, n_free;
    logic       r_hasbest, n_hasbest;
    logic [IW-1:0] r_best, n_best;
    logic       r_anyfit, n_anyfit;
    logic [2:0]  r_status;
    logic [15:0] r_okey;
    logic [31:0] r_oaddr;
    logic [15:0] r_oport;
    logic        out_take;

    logic [AW-1:0] req [3];
    logic [AW-1:0] free_amt [3];
    logic          fit_i, better, last;

    function automatic logic [AW-1:0] f_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
        f_sub = (a > b) ? a - b : '0;
    endfunction

    function automatic logic [AW-1:0] f_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        f_add = (s > AMAX) ? AMAX[AW-1:0] : s[AW-1:0];
    endfunction

    // requests masked or zero-extended to the amount width
    always_comb begin
        req[0] = AW'(r_it.ram);
        req[1] = AW'(r_it.disk);
        req[2] = AW'(r_it.cpu);
    end

    // per-slot fit check on the scanned slot
    always_comb begin
        fit_i = 1'b1;
        for (int k = 0; k < 3; k++) begin
            free_amt[k] = f_sub(f_sub(r_tot[r_idx][k], r_used[r_idx][k]), r_held[r_idx][k]);
            if (!(req[k] < free_amt[k])) fit_i = 1'b0;
        end
    end

    // candidate compare against current best
    always_comb begin
        if (i_search_mode == SEARCH_FIRST_FIT) begin
            better = r_key[r_idx] < r_key[r_best];
        end else begin
            better = (r_apps[r_idx] < r_apps[r_best]) ||
                     (r_apps[r_idx] == r_apps[r_best] && r_key[r_idx] < r_key[r_best]);
        end
    end

    assign last     = (r_idx == IW'(NUM_HOSTS - 1));
    assign out_take = o_valid && !i_stall;
    assign o_valid  = (r_st == BK_OUT);
    assign o_status = r_status;
    assign o_chosen_key = r_okey;
    assign o_chosen_address = r_oaddr;
    assign o_chosen_port    = r_oport;

    // sequencer
    always_comb begin
        n_st = r_st; n_idx = r_idx;
        n_found = r_found; n_fslot = r_fslot;
        n_hasfree = r_hasfree; n_free = r_free;
        n_hasbest = r_hasbest; n_best = r_best; n_anyfit = r_anyfit;
        o_q_pop = 1'b0;
        case (r_st)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_st = BK_SCAN; n_idx = '0;
                    n_found = 1'b0; n_hasfree = 1'b0;
                    n_hasbest = 1'b0; n_anyfit = 1'b0;
                end
            end
            BK_SCAN: begin
                if (r_valid[r_idx]) begin
                    if (!r_found && r_key[r_idx] == r_it.key) begin
                        n_found = 1'b1; n_fslot = r_idx;
                    end
                    if (fit_i) n_anyfit = 1'b1;
                    if (fit_i && r_key[r_idx] != i_local_key && (!r_hasbest || better)) begin
                        n_hasbest = 1'b1; n_best = r_idx;
                    end
                end else if (!r_hasfree) begin
                    n_hasfree = 1'b1; n_free = r_idx;
                end
                if (last) n_st = BK_EXEC;
                else n_idx = r_idx + 1'b1;
            end
            BK_EXEC: n_st = BK_OUT;
            BK_OUT:  if (!i_stall) n_st = BK_IDLE;
            default: n_st = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_found <= n_found; r_fslot <= n_fslot;
        r_hasfree <= n_hasfree; r_free <= n_free;
        r_hasbest <= n_hasbest; r_best <= n_best; r_anyfit <= n_anyfit;
        if (o_q_pop) r_it <= i_q_item;
    end

    // execute: update table and form the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (r_st == BK_EXEC) begin
            if (r_it.op == OP_REGISTER && !r_found && r_hasfree) begin
                r_valid[r_free] <= 1'b1;
            end
            if (r_it.op == OP_UNREGISTER && r_found) begin
                r_valid[r_fslot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == BK_EXEC) begin
            r_status <= ST_OK;
            r_okey   <= r_it.key;
            r_oaddr  <= '0;
            r_oport  <= '0;
            case (r_it.op)
                OP_REGISTER: begin
                    if (r_found) r_status <= ST_DUPLICATE;
                    else if (!r_hasfree) r_status <= ST_FULL;
                    else begin
                        r_key[r_free]  <= r_it.key;
                        r_addr[r_free] <= r_it.addr;
                        r_port[r_free] <= r_it.port;
                        r_apps[r_free] <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_tot[r_free][k]  <= req[k];
                            r_used[r_free][k] <= '0;
                            r_held[r_free][k] <= '0;
                        end
                    end
                end
                OP_PLACE: begin
                    if (!r_hasbest) r_status <= ST_NO_FIT;
                    else begin
                        for (int k = 0; k < 3; k++)
                            r_held[r_best][k] <= f_add(r_held[r_best][k], req[k]);
                        if (r_apps[r_best] != 8'hFF) r_apps[r_best] <= r_apps[r_best] + 8'd1;
                        r_okey  <= r_key[r_best];
                        r_oaddr <= r_addr[r_best];
                        r_oport <= r_port[r_best];
                    end
                end
                OP_QUERY: begin
                    if (!r_anyfit) r_status <= ST_NO_FIT;
                end
                OP_UNREGISTER, OP_COMMIT, OP_ABORT, OP_TERMINATE: begin
                    if (!r_found) r_status <= ST_NOT_FOUND;
                    else if (r_it.op == OP_COMMIT) begin
                        for (int k = 0; k < 3; k++) begin
                            r_held[r_fslot][k] <= f_sub(r_held[r_fslot][k], req[k]);
                            r_used[r_fslot][k] <= f_add(r_used[r_fslot][k], req[k]);
                        end
                    end else if (r_it.op != OP_UNREGISTER) begin
                        if (r_apps[r_fslot] != 8'd0) r_apps[r_fslot] <= r_apps[r_fslot] - 8'd1;
                        if (r_it.op == OP_TERMINATE) begin
                            for (int k = 0; k < 3; k++)
                                r_used[r_fslot][k] <= f_sub(r_used[r_fslot][k], req[k]);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_st == BK_IDLE) else $error("pop outside idle");
    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == BK_EXEC |=> r_st == BK_OUT) else $error("exec not followed by output");
    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == BK_EXEC && r_it.op == OP_PLACE && r_hasbest) |-> r_valid[r_best])
        else $error("placement chose empty slot");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_host_resource_placement_table_top.sv
`timescale 1ns / 100ps
module tb_host_resource_placement_table_top;
    import hrpt_pkg::*;

    localparam int HOSTS      = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT = 25;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] key;
        logic [31:0] addr;
        logic [15:0] port;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_mode = '0;
    logic [15:0] i_node_key = '0;
    logic [31:0] i_ram_amount = '0;
    logic [31:0] i_disk_amount = '0;
    logic [31:0] i_cpu_amount = '0;
    logic [31:0] i_host_address = '0;
    logic [15:0] i_host_port = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_chosen_key;
    logic [31:0] o_chosen_address;
    logic [15:0] o_chosen_port;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    host_resource_placement_table_top dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow of the host table
    logic        cfg_least_loaded;
    logic [15:0] cfg_own_key;
    logic        h_valid [HOSTS];
    logic [15:0] h_key   [HOSTS];
    logic [31:0] h_addr  [HOSTS];
    logic [15:0] h_port  [HOSTS];
    logic [31:0] h_tot   [HOSTS][3];
    logic [31:0] h_used  [HOSTS][3];
    logic [31:0] h_held  [HOSTS][3];
    logic [7:0]  h_apps  [HOSTS];

    t_outcome    pending_results [$];
    logic [15:0] key_pool [20];
    int          tx_idle = 0;
    int          rx_idle = 0;
    int          errors = 0;
    int          quiet_cycles = 0;

    function automatic logic [31:0] sub_sat(logic [31:0] a, logic [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic host_fits(int k, logic [31:0] req [3]);
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < 3; j++)
            if (!(req[j] < sub_sat(sub_sat(h_tot[k][j], h_used[k][j]), h_held[k][j])))
                ok = 1'b0;
        return ok;
    endfunction

    // applies one item to the shadow table and returns its result
    function automatic t_outcome apply_host_op(t_item it);
        t_outcome    o;
        int          s, b;
        logic [31:0] req [3];
        req[0] = it.ram; req[1] = it.disk; req[2] = it.cpu;
        o.status = ST_OK; o.key = it.key; o.addr = '0; o.port = '0;
        s = -1;
        for (int k = 0; k < HOSTS; k++)
            if (s < 0 && h_valid[k] && h_key[k] == it.key) s = k;
        case (it.op)
            OP_REGISTER: begin
                b = -1;
                for (int k = 0; k < HOSTS; k++)
                    if (b < 0 && !h_valid[k]) b = k;
                if (s >= 0) o.status = ST_DUPLICATE;
                else if (b < 0) o.status = ST_FULL;
                else begin
                    h_valid[b] = 1'b1; h_key[b] = it.key;
                    h_addr[b] = it.addr; h_port[b] = it.port;
                    for (int j = 0; j < 3; j++) begin
                        h_tot[b][j] = req[j]; h_used[b][j] = '0; h_held[b][j] = '0;
                    end
                    h_apps[b] = '0;
                end
            end
            OP_PLACE: begin
                b = -1;
                for (int k = 0; k < HOSTS; k++) begin
                    if (h_valid[k] && h_key[k] != cfg_own_key && host_fits(k, req)) begin
                        if (b < 0) b = k;
                        else if (!cfg_least_loaded) begin
                            if (h_key[k] < h_key[b]) b = k;
                        end else if (h_apps[k] < h_apps[b] ||
                                     (h_apps[k] == h_apps[b] && h_key[k] < h_key[b]))
                            b = k;
                    end
                end
                if (b < 0) o.status = ST_NO_FIT;
                else begin
                    for (int j = 0; j < 3; j++) h_held[b][j] = add_sat(h_held[b][j], req[j]);
                    if (h_apps[b] != 8'hFF) h_apps[b]++;
                    o.key = h_key[b]; o.addr = h_addr[b]; o.port = h_port[b];
                end
            end
            OP_QUERY: begin
                o.status = ST_NO_FIT;
                for (int k = 0; k < HOSTS; k++)
                    if (h_valid[k] && host_fits(k, req)) o.status = ST_OK;
            end
            OP_UNREGISTER, OP_COMMIT, OP_ABORT, OP_TERMINATE: begin
                if (s < 0) o.status = ST_NOT_FOUND;
                else if (it.op == OP_UNREGISTER) h_valid[s] = 1'b0;
                else if (it.op == OP_COMMIT) begin
                    for (int j = 0; j < 3; j++) begin
                        h_held[s][j] = sub_sat(h_held[s][j], req[j]);
                        h_used[s][j] = add_sat(h_used[s][j], req[j]);
                    end
                end else begin
                    if (h_apps[s] != 8'h00) h_apps[s]--;
                    if (it.op == OP_TERMINATE)
                        for (int j = 0; j < 3; j++) h_used[s][j] = sub_sat(h_used[s][j], req[j]);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // drives one item; called right after a rising edge, returns at the accepting edge
    task automatic send_item(t_item it);
        if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle);
        end
        i_valid <= 1'b1;
        i_mode <= it.op; i_node_key <= it.key;
        i_ram_amount <= it.ram; i_disk_amount <= it.disk; i_cpu_amount <= it.cpu;
        i_host_address <= it.addr; i_host_port <= it.port;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        pending_results.push_back(apply_host_op(it));
    endtask

    task automatic send_op(t_op op, logic [15:0] key, logic [31:0] r, logic [31:0] d,
                           logic [31:0] c, logic [31:0] addr = '0, logic [15:0] port = '0);
        t_item it;
        it.op = op; it.key = key; it.ram = r; it.disk = d; it.cpu = c;
        it.addr = addr; it.port = port;
        send_item(it);
    endtask

    // register write once the table has drained
    task automatic write_cfg(logic idx, logic [15:0] data);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        if (idx == CFG_SEARCH_MODE) cfg_least_loaded = data[0];
        else cfg_own_key = data;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_amount(logic is_total);
        int p;
        p = $urandom_range(99);
        if (p < 10) return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd0;
        if (p < 30) return $urandom;
        return is_total ? $urandom_range(100000, 1000) : $urandom_range(5000, 0);
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    p;
        p = $urandom_range(99);
        if (p < 20) it.op = OP_REGISTER;
        else if (p < 28) it.op = OP_UNREGISTER;
        else if (p < 53) it.op = OP_PLACE;
        else if (p < 68) it.op = OP_COMMIT;
        else if (p < 75) it.op = OP_ABORT;
        else if (p < 85) it.op = OP_TERMINATE;
        else if (p < 97) it.op = OP_QUERY;
        else it.op = OP_NONE;
        it.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(19)] : 16'($urandom);
        it.ram = rand_amount(it.op == OP_REGISTER);
        it.disk = rand_amount(it.op == OP_REGISTER);
        it.cpu = rand_amount(it.op == OP_REGISTER);
        it.addr = $urandom;
        it.port = 16'($urandom);
        return it;
    endfunction

    task automatic run_random(int count, int tx, int rx);
        tx_idle = tx; rx_idle = rx;
        repeat (count) send_item(rand_item());
    endtask

    // edge values, every op, duplicate, full table, unknown hosts, local host skip
    task automatic test_directed();
        send_op(OP_REGISTER, 16'h0000, '1, '1, '1, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(OP_REGISTER, 16'hFFFF, '0, '0, '0, 32'h0, 16'h0);
        send_op(OP_REGISTER, 16'h0000, 32'd5, 32'd5, 32'd5);
        send_op(OP_PLACE, 16'h1234, '0, '0, '0);
        send_op(OP_QUERY, 16'h0000, '0, '0, '0);
        send_op(OP_COMMIT, 16'h0000, 32'd7, 32'd7, 32'd7);
        send_op(OP_ABORT, 16'h0000, '0, '0, '0);
        send_op(OP_TERMINATE, 16'h0000, '1, '1, '1);
        send_op(OP_COMMIT, 16'h5555, '0, '0, '0);
        send_op(OP_ABORT, 16'hAAAA, '0, '0, '0);
        send_op(OP_TERMINATE, 16'h5555, '0, '0, '0);
        send_op(OP_UNREGISTER, 16'hAAAA, '0, '0, '0);
        send_op(OP_NONE, 16'h7777, '1, '1, '1, '1, '1);
        for (int k = 1; k <= 14; k++)
            send_op(OP_REGISTER, key_pool[k], 32'd50000, 32'd50000, 32'd50000,
                    $urandom, 16'($urandom));
        send_op(OP_REGISTER, 16'h4242, '1, '1, '1);
        send_op(OP_PLACE, 16'h0, 32'd100, 32'd100, 32'd100);
        send_op(OP_PLACE, 16'h0, '1, '1, '1);
        send_op(OP_UNREGISTER, 16'hFFFF, '0, '0, '0);
    endtask

    task automatic test_first_fit();
        write_cfg(CFG_SEARCH_MODE, {15'd0, SEARCH_FIRST_FIT});
        write_cfg(CFG_LOCAL_KEY, key_pool[3]);
        run_random(420, 33, 75);
    endtask

    task automatic test_least_loaded();
        write_cfg(CFG_SEARCH_MODE, {15'd0, SEARCH_LEAST_LOADED});
        write_cfg(CFG_LOCAL_KEY, 16'hFFFF);
        run_random(420, 75, 33);
    endtask

    task automatic test_full_rate();
        write_cfg(CFG_SEARCH_MODE, {15'd0, SEARCH_FIRST_FIT});
        write_cfg(CFG_LOCAL_KEY, key_pool[0]);
        run_random(420, 0, 0);
    endtask

    // receiver back-pressure
    always @(posedge i_clk)
        i_stall <= (rx_idle > 0) && ($urandom_range(99) < rx_idle);

    // result check: sampled mid-cycle, accepted at the next rising edge
    always @(negedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item status=%0d key=%h", $time, o_status,
                         o_chosen_key);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_chosen_key !== e.key) begin
                    $display("%0t: chosen_key exp %h got %h", $time, e.key, o_chosen_key);
                    errors++;
                end
                if (o_chosen_address !== e.addr) begin
                    $display("%0t: chosen_address exp %h got %h", $time, e.addr,
                             o_chosen_address);
                    errors++;
                end
                if (o_chosen_port !== e.port) begin
                    $display("%0t: chosen_port exp %h got %h", $time, e.port, o_chosen_port);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 20; k++) key_pool[k] = 16'(k * 4099 + 3);
        cfg_least_loaded = 1'b0;
        cfg_own_key = '0;
        for (int k = 0; k < HOSTS; k++) begin
            h_valid[k] = 1'b0; h_apps[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_first_fit();
        test_least_loaded();
        test_full_rate();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: host_resource_placement_table_top.f
rtl/hrpt_pkg.sv
rtl/hrpt_front.sv
rtl/hrpt_back.sv
rtl/host_resource_placement_table_top.sv
bench/tb_host_resource_placement_table_top.sv
